@@ design/hlmd_pkg.sv @@
// ----------------------------------------------------------------------------
// hlmd_pkg
// Shared types, constants and helper functions for the Hadamard / Lloyd-Max
// block dequantizer.
// ----------------------------------------------------------------------------
package hlmd_pkg;

    localparam int BLOCK_LEN_DEF = 128;
    localparam int FRAC_BITS_DEF = 14;

    // field widths
    localparam int CODE_W  = 8;
    localparam int HALF_W  = 16;
    localparam int OUT_W   = 35;
    localparam int SEED_W  = 32;
    localparam int CORR_W  = 14;
    localparam int MANT_W  = 11;
    localparam int EXP_MAX = 29;   // largest unbiased shift of a finite half

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_STEP = 1'b1;

    localparam logic [SEED_W-1:0] SEED_RST = 32'd42;
    localparam logic [CORR_W-1:0] CORR_RST = 14'd724;

    localparam logic [OUT_W-1:0] POS_LIMIT = 35'h3_FFFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIMIT = 35'h4_0000_0000;

    // positive Lloyd-Max centroids for N(0,1), scaled by 1e10
    localparam longint unsigned TEN_E10 = 64'd10000000000;
    localparam longint unsigned CENT_E10 [8] = '{
        64'd1317577823,  64'd3978971029,  64'd6723921169,  64'd9626409783,
        64'd12797397520, 64'd16430415100, 64'd20935627070, 64'd27543548070
    };

    typedef logic [7:0][31:0] t_cent_tab;

    // centroid magnitudes rounded to frac fraction bits
    function automatic t_cent_tab cent_table(input int frac);
        t_cent_tab       tab;
        longint unsigned m;
        for (int k = 0; k < 8; k++) begin
            m = ((CENT_E10[k] << frac) + TEN_E10 / 2) / TEN_E10;
            tab[k] = m[31:0];
        end
        return tab;
    endfunction

    function automatic logic [SEED_W-1:0] xs32(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

@@ design/hadamard_lloyd_max_dequantizer_top.sv @@
// ----------------------------------------------------------------------------
// hadamard_lloyd_max_dequantizer_top
// Collects a block of 4-bit Lloyd-Max codes, adds the signed residual
// correction, runs an in-place Walsh-Hadamard transform and emits the block
// scaled by norm/BLOCK_LEN as saturated Q18.16 pairs.
// ----------------------------------------------------------------------------
// Code bytes are accepted in the idle state while a block fills. The byte
// that completes the block starts the transform: one shared butterfly unit
// works through LOG2(BLOCK_LEN) stages of BLOCK_LEN/2 butterflies, one per
// cycle, with a drain state after each stage, over two parity-banked
// coordinate memories. The pairs then go through one shared multiplier and
// rounding/saturating shifter: after a read state, each pair passes through
// the even multiply, odd multiply and scale states, and the scale state
// waits while the output is stalled. A full block is BLOCK_LEN/2 code bytes.
// The input is stalled from the last byte of a block until its last pair has
// been loaded into the output register; that pair may wait there while the
// next block fills.
module hadamard_lloyd_max_dequantizer_top #(
    parameter int BLOCK_LEN = hlmd_pkg::BLOCK_LEN_DEF,
    parameter int FRAC_BITS = hlmd_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // code byte channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [hlmd_pkg::CODE_W-1:0]          i_code_byte,
    input  logic [hlmd_pkg::HALF_W-1:0]          i_norm_half,
    input  logic                                 i_residual_sign,
    // pair channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [hlmd_pkg::OUT_W-1:0]    o_value_even,
    output logic signed [hlmd_pkg::OUT_W-1:0]    o_value_odd,
    output logic                                 o_last_pair,
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hlmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hlmd_pkg::SEED_W-1:0]          i_cfg_data
);
    import hlmd_pkg::*;

    localparam int LOG2    = $clog2(BLOCK_LEN);
    localparam int PAIRS   = BLOCK_LEN / 2;
    localparam int PAIR_W  = $clog2(PAIRS);
    localparam int STG_W   = $clog2(LOG2);
    localparam int MAGW    = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
    localparam int COORD_W = MAGW + 1 + LOG2;
    localparam int PW      = COORD_W + MANT_W;
    localparam int SCL     = FRAC_BITS + 8 + LOG2;
    localparam int LMAX    = (EXP_MAX > SCL) ? EXP_MAX - SCL : 0;
    localparam int SW_RAW  = PW + LMAX + 1;
    localparam int SW      = (SW_RAW > OUT_W + 1) ? SW_RAW : OUT_W + 1;
    localparam int AMT_W   = $clog2(((SCL > EXP_MAX) ? SCL : EXP_MAX) + 1);
    localparam t_cent_tab CENT = cent_table(FRAC_BITS);
    localparam logic [PAIR_W-1:0] LAST_IDX  = PAIR_W'(PAIRS - 1);
    localparam logic [STG_W-1:0]  LAST_STG  = STG_W'(LOG2 - 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BF     = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_OUT_RD = 7'b0001000,
        S_OUT_ME = 7'b0010000,
        S_OUT_MO = 7'b0100000,
        S_OUT_SC = 7'b1000000
    } t_state;

    function automatic logic signed [COORD_W-1:0] cent_val(input logic [3:0] c);
        logic [2:0]         k;
        logic [COORD_W-1:0] m;
        k = c[3] ? c[2:0] : ~c[2:0];
        m = COORD_W'(CENT[k]);
        return c[3] ? signed'(m) : -signed'(m);
    endfunction

    // ------------------------------------------------------------------
    // state
    t_state                     r_state, n_state;
    logic [PAIR_W-1:0]          r_byte_cnt;
    logic [PAIR_W-1:0]          r_bf;
    logic [STG_W-1:0]           r_stage;
    logic [PAIR_W-1:0]          r_pair;

    logic [SEED_W-1:0]          r_sign_seed;
    logic [CORR_W-1:0]          r_corr_step;

    // per-block latched values
    logic [SEED_W-1:0]          r_xs;
    logic [CORR_W-1:0]          r_corr;
    logic                       r_blk_sign;
    logic [MANT_W-1:0]          r_mant;
    logic                       r_lsh;
    logic [AMT_W-1:0]           r_amt;
    logic                       r_inf;
    logic                       r_nneg;

    // coordinate memories, banked by index parity
    logic signed [COORD_W-1:0]  r_mem0 [PAIRS];
    logic signed [COORD_W-1:0]  r_mem1 [PAIRS];
    logic signed [COORD_W-1:0]  r_rd0, r_rd1;
    logic                       rd_en, we0, we1;
    logic [PAIR_W-1:0]          ra0, ra1, wa0, wa1;
    logic signed [COORD_W-1:0]  wd0, wd1;

    // butterfly write-back stage
    logic                       r_bf_wr;
    logic                       r_bf_swap;
    logic                       r_bf_first;
    logic [PAIR_W-1:0]          r_wa_j, r_wa_p;
    logic                       r_sa, r_sc;

    // output path
    logic                       r_opar;
    logic [PW-1:0]              r_prod;
    logic                       r_pneg, r_pnz;
    logic signed [OUT_W-1:0]    r_q_even;
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_even, r_out_odd;
    logic                       r_out_last;

    logic                       in_acc, last_byte, out_free, out_load;

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign last_byte = in_acc && (r_byte_cnt == LAST_IDX);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == S_OUT_SC) && out_free;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_value_even = r_out_even;
    assign o_value_odd  = r_out_odd;
    assign o_last_pair  = r_out_last;

    // ------------------------------------------------------------------
    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (last_byte) n_state = S_BF;
            S_BF:     if (r_bf == LAST_IDX) n_state = S_DRAIN;
            S_DRAIN:  n_state = (r_stage == LAST_STG) ? S_OUT_RD : S_BF;
            S_OUT_RD: n_state = S_OUT_ME;
            S_OUT_ME: n_state = S_OUT_MO;
            S_OUT_MO: n_state = S_OUT_SC;
            S_OUT_SC: begin
                if (out_free) n_state = (r_pair == LAST_IDX) ? S_IDLE : S_OUT_ME;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte_cnt  <= '0;
            r_bf        <= '0;
            r_stage     <= '0;
            r_pair      <= '0;
            r_sign_seed <= SEED_RST;
            r_corr_step <= CORR_RST;
            r_bf_wr     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SIGN_SEED) r_sign_seed <= i_cfg_data;
                if (i_cfg_index == CFG_CORR_STEP) r_corr_step <= i_cfg_data[CORR_W-1:0];
            end
            if (in_acc) r_byte_cnt <= r_byte_cnt + 1'b1;
            r_bf_wr <= (r_state == S_BF);
            if (r_state == S_BF) r_bf <= r_bf + 1'b1;
            if (r_state == S_DRAIN) begin
                r_stage <= (r_stage == LAST_STG) ? '0 : r_stage + 1'b1;
            end
            if (out_load) r_pair <= (r_pair == LAST_IDX) ? '0 : r_pair + 1'b1;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // norm decode and per-block latches
    logic [4:0]       h_exp;
    logic [AMT_W-1:0] h_e, scl_c;

    always_comb begin
        h_exp = i_norm_half[14:10];
        h_e   = (h_exp == 5'd0) ? '0 : AMT_W'(h_exp - 5'd1);
        scl_c = AMT_W'(SCL);
    end

    always_ff @(posedge i_clk) begin
        if (last_byte) begin
            r_corr     <= r_corr_step;
            r_blk_sign <= i_residual_sign;
            r_mant     <= {(h_exp != 5'd0), i_norm_half[9:0]};
            r_inf      <= (h_exp == 5'd31);
            r_nneg     <= i_norm_half[15];
            r_lsh      <= (h_e >= scl_c);
            r_amt      <= (h_e >= scl_c) ? h_e - scl_c : scl_c - h_e;
        end
    end

    // ------------------------------------------------------------------
    // butterfly addressing: j has a zero inserted at bit r_stage, partner sets it
    logic [LOG2-1:0]   bf_ext, bf_mask, bf_j, bf_p;
    logic              bf_par;
    logic [SEED_W-1:0] xs1, xs2;

    always_comb begin
        bf_ext  = LOG2'(r_bf);
        bf_mask = (LOG2'(1) << r_stage) - 1'b1;
        bf_j    = ((bf_ext & ~bf_mask) << 1) | (bf_ext & bf_mask);
        bf_p    = bf_j | (LOG2'(1) << r_stage);
        bf_par  = ^bf_j;
        xs1     = xs32(r_xs);
        xs2     = xs32(xs1);
    end

    always_ff @(posedge i_clk) begin
        if (last_byte) begin
            r_xs <= (r_sign_seed != '0) ? r_sign_seed : SEED_W'(1);
        end else if (r_state == S_BF && r_stage == '0) begin
            r_xs <= xs2;
        end
        if (r_state == S_BF) begin
            r_bf_swap  <= bf_par;
            r_bf_first <= (r_stage == '0);
            r_wa_j     <= bf_j[LOG2-1:1];
            r_wa_p     <= bf_p[LOG2-1:1];
            r_sa       <= xs1[0];
            r_sc       <= xs2[0];
        end
    end

    // shared butterfly unit, with the residual correction folded into stage 0
    logic signed [COORD_W-1:0] bf_a, bf_c, corr_pos, bf_sum, bf_dif;

    always_comb begin
        corr_pos = COORD_W'(r_corr);
        bf_a     = r_bf_swap ? r_rd1 : r_rd0;
        bf_c     = r_bf_swap ? r_rd0 : r_rd1;
        if (r_bf_first) begin
            bf_a = (r_sa == r_blk_sign) ? bf_a + corr_pos : bf_a - corr_pos;
            bf_c = (r_sc == r_blk_sign) ? bf_c + corr_pos : bf_c - corr_pos;
        end
        bf_sum = bf_a + bf_c;
        bf_dif = bf_a - bf_c;
    end

    // ------------------------------------------------------------------
    // memory ports
    logic [PAIR_W-1:0]         rd_pair;
    logic signed [COORD_W-1:0] cent_lo, cent_hi;
    logic                      byte_par;

    always_comb begin
        cent_lo  = cent_val(i_code_byte[3:0]);
        cent_hi  = cent_val(i_code_byte[7:4]);
        byte_par = ^r_byte_cnt;
        rd_pair  = (r_state == S_OUT_SC) ? r_pair + 1'b1 : r_pair;

        rd_en = 1'b0;
        ra0   = rd_pair;
        ra1   = rd_pair;
        if (r_state == S_BF) begin
            rd_en = 1'b1;
            ra0   = bf_par ? bf_p[LOG2-1:1] : bf_j[LOG2-1:1];
            ra1   = bf_par ? bf_j[LOG2-1:1] : bf_p[LOG2-1:1];
        end else if (r_state == S_OUT_RD) begin
            rd_en = 1'b1;
        end else if (out_load && r_pair != LAST_IDX) begin
            rd_en = 1'b1;
        end

        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = r_byte_cnt;
        wa1 = r_byte_cnt;
        wd0 = byte_par ? cent_hi : cent_lo;
        wd1 = byte_par ? cent_lo : cent_hi;
        if (in_acc) begin
            we0 = 1'b1;
            we1 = 1'b1;
        end else if (r_bf_wr) begin
            we0 = 1'b1;
            we1 = 1'b1;
            wa0 = r_bf_swap ? r_wa_p : r_wa_j;
            wa1 = r_bf_swap ? r_wa_j : r_wa_p;
            wd0 = r_bf_swap ? bf_dif : bf_sum;
            wd1 = r_bf_swap ? bf_sum : bf_dif;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) r_mem0[wa0] <= wd0;
        if (rd_en) r_rd0 <= r_mem0[ra0];
    end

    always_ff @(posedge i_clk) begin
        if (we1) r_mem1[wa1] <= wd1;
        if (rd_en) r_rd1 <= r_mem1[ra1];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_opar <= ^rd_pair;
    end

    // ------------------------------------------------------------------
    // shared multiplier: |coord| * mantissa
    logic signed [COORD_W-1:0] m_a;
    logic [COORD_W-1:0]        m_abs;
    logic [PW-1:0]             m_prod;

    always_comb begin
        m_a    = ((r_state == S_OUT_ME) == !r_opar) ? r_rd0 : r_rd1;
        m_abs  = m_a[COORD_W-1] ? COORD_W'(-m_a) : COORD_W'(m_a);
        m_prod = PW'(m_abs) * PW'(r_mant);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_ME || r_state == S_OUT_MO) begin
            r_prod <= m_prod;
            r_pneg <= m_a[COORD_W-1] ^ r_nneg;
            r_pnz  <= (m_a != '0);
        end
    end

    // shared scaler: exponent shift, round half up, saturate, apply sign
    logic [SW-1:0]           s_ext, s_half, s_qw, s_lim, s_q;
    logic [OUT_W-1:0]        s_q35;
    logic signed [OUT_W-1:0] s_val;

    always_comb begin
        s_ext  = SW'(r_prod);
        s_half = (SW'(1) << r_amt) >> 1;
        s_qw   = r_lsh ? (s_ext << r_amt) : ((s_ext + s_half) >> r_amt);
        s_lim  = SW'(r_pneg ? NEG_LIMIT : POS_LIMIT);
        if (r_inf) s_q = r_pnz ? s_lim : '0;
        else       s_q = (s_qw > s_lim) ? s_lim : s_qw;
        s_q35  = s_q[OUT_W-1:0];
        s_val  = r_pneg ? -signed'(s_q35) : signed'(s_q35);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_MO) r_q_even <= s_val;
        if (out_load) begin
            r_out_even <= r_q_even;
            r_out_odd  <= s_val;
            r_out_last <= (r_pair == LAST_IDX);
        end
    end

    // ------------------------------------------------------------------
    // checks
    a_busy_at_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_byte_cnt == '0))
        else $error("byte count not at block start while transform busy");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_bf_wr && in_acc))
        else $error("byte write collides with butterfly write-back");

    a_bf_wr_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF) |=> r_bf_wr)
        else $error("butterfly issued without write-back");

    a_sign_gen_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF && r_stage == '0) |-> (r_xs != '0))
        else $error("sign generator stuck at zero");

endmodule
